FILE: sv/iol_pkg.sv
// Shared types and constants for the indexed ordered list.
`default_nettype none
package iol_pkg;

  localparam int CAPACITY  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 6;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_READOUT  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } iol_mem_req_t;

endpackage
`default_nettype wire

FILE: sv/iol_store.sv
// Entry storage: one write port, one read port with registered read data.
`default_nettype none
module iol_store
  import iol_pkg::*;
(
  input  wire logic             clk_i,
  input  wire iol_mem_req_t     req_i,
  output logic      [VAL_W-1:0] rd_data_o
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: sv/indexed_ordered_list.sv
// Top level of the indexed ordered list: operation sequencer and output register.
//
// Input words carry one operation: insert at head, tail or a position, delete
// at head, tail or a position, or read out the list. Opcode rides in tuser.
// Each operation except read out returns one word with status and new count;
// read out returns one word per entry, head first, tlast on the last one, or
// a single empty-status word for an empty list. Opcode 7 is dropped.
//
// Entries live in a memory with one write port and one read port. Each entry
// moved is read (S_INS_RD or S_DEL_RD) and then written (S_INS_WR or S_DEL_WR);
// an insert ends by writing the new value in S_INS_NEW, and read out reads each
// entry in S_RO_RD and loads it into the output register in S_RO_OUT.
// One operation is in flight at a time; s_axis_tready_o is high only when
// the sequencer is idle. A finished result sits in the output register, so
// the next operation may be accepted while it waits. When the receiver
// stalls, the sequencer holds before loading the next result.
// Reset clears the count to zero; memory contents need no clearing.
`default_nettype none
module indexed_ordered_list
  import iol_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // item_value[31:0], position[37:32], zero pad
  input  wire logic [2:0]  s_axis_tuser_i,   // opcode[2:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,   // out_value[31:0], entry_count[37:32], zero pad
  output logic      [1:0]  m_axis_tuser_o,   // status[1:0]
  output logic             m_axis_tlast_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_DEL_RD,
    S_DEL_WR,
    S_RO_RD,
    S_RO_OUT,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] cur_q;
  logic [IDX_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  status_e          st_q;

  logic                 out_valid_q;
  logic [VAL_W-1:0]     out_value_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  status_e              out_st_q;
  logic                 out_last_q;

  iol_mem_req_t     mem_req;
  logic [VAL_W-1:0] rd_data;

  logic             in_acc;
  logic             out_free;
  op_e              op;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [CMP_W-1:0] cnt_w;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign op       = op_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[VAL_W-1:0];
  assign in_pos   = s_axis_tdata_i[VAL_W+POS_W-1:VAL_W];
  assign cnt_w    = CMP_W'(cnt_q);

  iol_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_comb begin
    mem_req = '0;
    case (state_q)
      S_INS_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cur_q - IDX_W'(1);
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_q;
        mem_req.wdata = rd_data;
      end
      S_INS_NEW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        mem_req.wdata = val_q;
      end
      S_DEL_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cur_q + IDX_W'(1);
      end
      S_DEL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_q;
        mem_req.wdata = rd_data;
      end
      S_RO_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cur_q;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [CMP_W-1:0] p;
    logic             out_load;
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_cnt_q   <= '0;
      out_st_q    <= ST_OK;
      out_last_q  <= 1'b0;
    end else begin
      p        = '0;
      out_load = 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            val_q <= in_value;
            case (op)
              OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (op == OP_INS_HEAD) begin
                  p = '0;
                end else if (op == OP_INS_TAIL) begin
                  p = cnt_w;
                end else begin
                  p = CMP_W'(in_pos);
                end
                if (p > cnt_w) begin
                  st_q    <= ST_BADPOS;
                  state_q <= S_RESP;
                end else if (cnt_w >= CMP_W'(CAPACITY)) begin
                  st_q    <= ST_FULL;
                  state_q <= S_RESP;
                end else begin
                  pos_q <= IDX_W'(p);
                  cur_q <= IDX_W'(cnt_q);
                  if (p == cnt_w) begin
                    state_q <= S_INS_NEW;
                  end else begin
                    state_q <= S_INS_RD;
                  end
                end
              end
              OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                if (op == OP_DEL_HEAD) begin
                  p = '0;
                end else if (op == OP_DEL_TAIL) begin
                  p = cnt_w - CMP_W'(1);
                end else begin
                  p = CMP_W'(in_pos);
                end
                if (cnt_q == '0) begin
                  st_q    <= ST_EMPTY;
                  state_q <= S_RESP;
                end else if (p >= cnt_w) begin
                  st_q    <= ST_BADPOS;
                  state_q <= S_RESP;
                end else if (p + CMP_W'(1) == cnt_w) begin
                  cnt_q   <= cnt_q - CNT_W'(1);
                  st_q    <= ST_OK;
                  state_q <= S_RESP;
                end else begin
                  cur_q   <= IDX_W'(p);
                  state_q <= S_DEL_RD;
                end
              end
              OP_READOUT: begin
                if (cnt_q == '0) begin
                  st_q    <= ST_EMPTY;
                  state_q <= S_RESP;
                end else begin
                  cur_q   <= '0;
                  state_q <= S_RO_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_WR;
        end
        S_INS_WR: begin
          cur_q <= cur_q - IDX_W'(1);
          if ((cur_q - IDX_W'(1)) == pos_q) begin
            state_q <= S_INS_NEW;
          end else begin
            state_q <= S_INS_RD;
          end
        end
        S_INS_NEW: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          st_q    <= ST_OK;
          state_q <= S_RESP;
        end
        S_DEL_RD: begin
          state_q <= S_DEL_WR;
        end
        S_DEL_WR: begin
          cur_q <= cur_q + IDX_W'(1);
          if (CMP_W'(cur_q) + CMP_W'(2) == cnt_w) begin
            cnt_q   <= cnt_q - CNT_W'(1);
            st_q    <= ST_OK;
            state_q <= S_RESP;
          end else begin
            state_q <= S_DEL_RD;
          end
        end
        S_RO_RD: begin
          state_q <= S_RO_OUT;
        end
        S_RO_OUT: begin
          if (out_free) begin
            out_load    = 1'b1;
            out_value_q <= rd_data;
            out_cnt_q   <= CNT_OUT_W'(cnt_q);
            out_st_q    <= ST_OK;
            out_last_q  <= (CMP_W'(cur_q) + CMP_W'(1) == cnt_w);
            if (CMP_W'(cur_q) + CMP_W'(1) == cnt_w) begin
              state_q <= S_IDLE;
            end else begin
              cur_q   <= cur_q + IDX_W'(1);
              state_q <= S_RO_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_load    = 1'b1;
            out_value_q <= '0;
            out_cnt_q   <= CNT_OUT_W'(cnt_q);
            out_st_q    <= st_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(40 - VAL_W - CNT_OUT_W){1'b0}}, out_cnt_q, out_value_q};
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (state_q == S_RESP))
    else $error("entry count changed outside operation completion");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == S_INS_WR || state_q == S_INS_NEW || state_q == S_DEL_WR))
    else $error("memory write outside insert or delete");

  a_run_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_st_q == ST_OK))
    else $error("non-final word without ok status");
`endif

endmodule
`default_nettype wire
